/* rtl/aarm_pkg.sv */
`default_nettype none
package aarm_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int QUO_BITS      = 16;

  // stage map of the datapath
  localparam int ST_NORM  = 1;
  localparam int ST_SCALE = 2;
  localparam int ST_SQRT  = 3;
  localparam int ST_DSET  = ST_SQRT + SQRT_STEPS;
  localparam int ST_DIV   = ST_DSET + 1;
  localparam int ST_UNIT  = ST_DIV + QUO_BITS;
  localparam int ST_TRIG  = CORDIC_STAGES + 1;
  localparam int ST_PROD  = ST_UNIT + 1;
  localparam int ST_WPROD = ST_PROD + 1;
  localparam int ST_OUT   = ST_WPROD + 1;
  localparam int NST      = ST_OUT + 1;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q    = 18'sd16384;
  localparam logic signed [17:0] MONE_Q   = -18'sd16384;

  typedef struct packed {
    logic [2:0]        sgn;
    logic [2:0][15:0]  mag0;
    logic              zero;
    logic [4:0]        sh;
    logic [2:0][31:0]  sq;
    logic [63:0]       v;
    logic [63:0]       r;
    logic [2:0][31:0]  mag;
    logic [32:0]       dd;
    logic [2:0][47:0]  rem;
    logic [2:0][15:0]  q;
    logic [2:0][15:0]  u;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic              neg;
    logic [15:0]       c;
    logic [15:0]       s;
    logic [16:0]       w;
    logic [5:0][17:0]  uu;
    logic [2:0][17:0]  us;
    logic [5:0][17:0]  wp;
    logic [8:0][15:0]  rr;
  } pipe_t;

  function automatic logic signed [33:0] atan_val(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sh20000000;
      5'd1:  a = 34'sh12E4051E;
      5'd2:  a = 34'sh09FB385B;
      5'd3:  a = 34'sh051111D4;
      5'd4:  a = 34'sh028B0D43;
      5'd5:  a = 34'sh0145D7E1;
      5'd6:  a = 34'sh00A2F61E;
      5'd7:  a = 34'sh00517C55;
      5'd8:  a = 34'sh0028BE53;
      5'd9:  a = 34'sh00145F2F;
      5'd10: a = 34'sh000A2F98;
      5'd11: a = 34'sh000517CC;
      5'd12: a = 34'sh00028BE6;
      5'd13: a = 34'sh000145F3;
      5'd14: a = 34'sh0000A2FA;
      5'd15: a = 34'sh0000517D;
      5'd16: a = 34'sh000028BE;
      5'd17: a = 34'sh0000145F;
      5'd18: a = 34'sh00000A30;
      5'd19: a = 34'sh00000518;
      5'd20: a = 34'sh0000028C;
      5'd21: a = 34'sh00000146;
      5'd22: a = 34'sh000000A3;
      5'd23: a = 34'sh00000051;
      5'd24: a = 34'sh00000029;
      5'd25: a = 34'sh00000014;
      5'd26: a = 34'sh0000000A;
      5'd27: a = 34'sh00000005;
      5'd28: a = 34'sh00000003;
      5'd29: a = 34'sh00000001;
      5'd30: a = 34'sh00000001;
      default: a = 34'sh0;
    endcase
    return a;
  endfunction

  // Q14 product, rounded half up
  function automatic logic signed [17:0] mulq(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    logic signed [35:0] p;
    p = a * b + 36'sd8192;
    return 18'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [15:0] clampq(input logic signed [17:0] v);
    logic [15:0] o;
    if (v > ONE_Q) o = 16'(ONE_Q);
    else if (v < MONE_Q) o = 16'(MONE_Q);
    else o = v[15:0];
    return o;
  endfunction

  function automatic logic signed [17:0] sx16(input logic [15:0] v);
    return $signed({{2{v[15]}}, v});
  endfunction

  function automatic pipe_t cordic_step(input pipe_t p, input logic [4:0] i);
    pipe_t o;
    logic signed [33:0] dx, dy, at;
    o  = p;
    dx = p.x >>> i;
    dy = p.y >>> i;
    at = atan_val(i);
    if (!p.z[33]) begin
      o.x = p.x - dy;
      o.y = p.y + dx;
      o.z = p.z - at;
    end else begin
      o.x = p.x + dy;
      o.y = p.y - dx;
      o.z = p.z + at;
    end
    return o;
  endfunction

  function automatic pipe_t norm_step(input pipe_t p);
    pipe_t o;
    logic [15:0] mx;
    logic [4:0]  msb;
    o  = p;
    mx = p.mag0[0];
    if (p.mag0[1] > mx) mx = p.mag0[1];
    if (p.mag0[2] > mx) mx = p.mag0[2];
    msb = 5'd0;
    for (int b = 0; b < 16; b++) begin
      if (mx[b]) msb = 5'(b);
    end
    o.sh   = 5'd30 - msb;
    o.zero = (mx == 16'd0);
    for (int k = 0; k < 3; k++) begin
      o.sq[k] = {16'd0, p.mag0[k]} * {16'd0, p.mag0[k]};
    end
    return o;
  endfunction

  function automatic pipe_t scale_step(input pipe_t p);
    pipe_t o;
    logic [63:0] sum;
    o   = p;
    sum = {32'd0, p.sq[0]} + {32'd0, p.sq[1]} + {32'd0, p.sq[2]};
    o.v = sum << {p.sh, 1'b0};
    o.r = 64'd0;
    for (int k = 0; k < 3; k++) begin
      o.mag[k] = {16'd0, p.mag0[k]} << p.sh;
    end
    return o;
  endfunction

  function automatic pipe_t sqrt_step(input pipe_t p, input logic [4:0] j);
    pipe_t o;
    logic [63:0] bitv, trial;
    o     = p;
    bitv  = 64'd1 << (6'd62 - {j, 1'b0});
    trial = p.r + bitv;
    if (p.v >= trial) begin
      o.v = p.v - trial;
      o.r = (p.r >> 1) + bitv;
    end else begin
      o.r = p.r >> 1;
    end
    return o;
  endfunction

  function automatic pipe_t div_setup(input pipe_t p);
    pipe_t o;
    o    = p;
    o.dd = {p.r[31:0], 1'b0};
    for (int k = 0; k < 3; k++) begin
      o.rem[k] = {1'b0, p.mag[k], 15'd0} + {16'd0, p.r[31:0]};
      o.q[k]   = 16'd0;
    end
    return o;
  endfunction

  function automatic pipe_t div_step(input pipe_t p, input logic [3:0] i);
    pipe_t o;
    logic [47:0] dsh;
    o   = p;
    dsh = {15'd0, p.dd} << i;
    for (int k = 0; k < 3; k++) begin
      if (p.rem[k] >= dsh) begin
        o.rem[k]  = p.rem[k] - dsh;
        o.q[k][i] = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic pipe_t unit_step(input pipe_t p);
    pipe_t o;
    o = p;
    for (int k = 0; k < 3; k++) begin
      if (p.zero) o.u[k] = 16'd0;
      else if (p.sgn[k]) o.u[k] = 16'd0 - p.q[k];
      else o.u[k] = p.q[k];
    end
    return o;
  endfunction

  function automatic pipe_t trig_step(input pipe_t p);
    pipe_t o;
    logic signed [33:0] xn, yn, xr, yr;
    logic signed [17:0] cc, ss;
    o  = p;
    xn = p.neg ? -p.x : p.x;
    yn = p.neg ? -p.y : p.y;
    xr = (xn + 34'sd32768) >>> 16;
    yr = (yn + 34'sd32768) >>> 16;
    cc = 18'(xr);
    ss = 18'(yr);
    if (xr > 34'sd16384) cc = ONE_Q;
    else if (xr < -34'sd16384) cc = MONE_Q;
    if (yr > 34'sd16384) ss = ONE_Q;
    else if (yr < -34'sd16384) ss = MONE_Q;
    o.c = cc[15:0];
    o.s = ss[15:0];
    o.w = 17'(ONE_Q - cc);
    return o;
  endfunction

  function automatic pipe_t prod_step(input pipe_t p);
    pipe_t o;
    o = p;
    for (int k = 0; k < 3; k++) begin
      o.uu[k] = mulq(sx16(p.u[k]), sx16(p.u[k])) - ONE_Q;
      o.us[k] = mulq(sx16(p.u[k]), sx16(p.s));
    end
    o.uu[3] = mulq(sx16(p.u[0]), sx16(p.u[1]));
    o.uu[4] = mulq(sx16(p.u[0]), sx16(p.u[2]));
    o.uu[5] = mulq(sx16(p.u[1]), sx16(p.u[2]));
    return o;
  endfunction

  function automatic pipe_t wprod_step(input pipe_t p);
    pipe_t o;
    o = p;
    for (int m = 0; m < 6; m++) begin
      o.wp[m] = mulq($signed({1'b0, p.w}), $signed(p.uu[m]));
    end
    return o;
  endfunction

  function automatic pipe_t out_step(input pipe_t p);
    pipe_t o;
    o = p;
    o.rr[0] = clampq(ONE_Q + $signed(p.wp[0]));
    o.rr[4] = clampq(ONE_Q + $signed(p.wp[1]));
    o.rr[8] = clampq(ONE_Q + $signed(p.wp[2]));
    o.rr[1] = clampq($signed(p.us[2]) + $signed(p.wp[3]));
    o.rr[3] = clampq($signed(p.wp[3]) - $signed(p.us[2]));
    o.rr[2] = clampq($signed(p.wp[4]) - $signed(p.us[1]));
    o.rr[6] = clampq($signed(p.us[1]) + $signed(p.wp[4]));
    o.rr[5] = clampq($signed(p.us[0]) + $signed(p.wp[5]));
    o.rr[7] = clampq($signed(p.wp[5]) - $signed(p.us[0]));
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/axis_angle_rotation_matrix_top.sv */
`default_nettype none
// Axis-angle to rotation matrix. Each input word (axis x/y/z, signed 16-bit at any scale,
// and a 16-bit binary angle, 65536 = one turn) yields one output word of nine Q1.14 matrix
// entries r00..r22, each saturated to +/-1. The axis is scaled to unit length by a
// pipelined integer square root (one result bit per stage) and a restoring divider (one
// quotient bit per stage, three lanes); cos/sin come from a 16-stage rotation CORDIC that
// runs alongside. A zero axis gives cos on the diagonal and zero elsewhere. The sine terms
// keep the transposed sign placement. Rate: one word per cycle while the pipe is not held;
// the pipe depth is set by the square root and divider stages. The whole pipe holds when
// out_valid is high and out_ready low, so in_ready follows that.
module axis_angle_rotation_matrix_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] axis_x,
  input  wire logic [15:0] axis_y,
  input  wire logic [15:0] axis_z,
  input  wire logic [15:0] turn_angle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      r00,
  output logic [15:0]      r01,
  output logic [15:0]      r02,
  output logic [15:0]      r10,
  output logic [15:0]      r11,
  output logic [15:0]      r12,
  output logic [15:0]      r20,
  output logic [15:0]      r21,
  output logic [15:0]      r22
);
  import aarm_pkg::*;

  pipe_t          stg      [NST];
  pipe_t          stg_next [NST];
  logic [NST-1:0] vld;
  logic           en;

  // global hold: a waiting result freezes every stage
  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en && !rst;

  always_comb begin
    logic [15:0] ax [3];
    ax[0] = axis_x;
    ax[1] = axis_y;
    ax[2] = axis_z;
    stg_next[0] = stg[0];
    for (int k = 0; k < 3; k++) begin
      stg_next[0].sgn[k]  = ax[k][15];
      stg_next[0].mag0[k] = ax[k][15] ? 16'd0 - ax[k] : ax[k];
    end
    // second and third quadrants: rotate by half a turn, negate at the end
    stg_next[0].neg = turn_angle[15] ^ turn_angle[14];
    stg_next[0].z   = $signed({{3{turn_angle[15] ^ stg_next[0].neg}},
                               turn_angle[14:0], 16'd0});
    stg_next[0].x   = GAIN_Q30;
    stg_next[0].y   = 34'sd0;

    for (int k = 1; k < NST; k++) begin
      stg_next[k] = stg[k-1];
      if (k <= CORDIC_STAGES) stg_next[k] = cordic_step(stg_next[k], 5'(k - 1));
      if (k == ST_TRIG)       stg_next[k] = trig_step(stg_next[k]);
      if (k == ST_NORM)       stg_next[k] = norm_step(stg_next[k]);
      if (k == ST_SCALE)      stg_next[k] = scale_step(stg_next[k]);
      if (k >= ST_SQRT && k < ST_DSET)
        stg_next[k] = sqrt_step(stg_next[k], 5'(k - ST_SQRT));
      if (k == ST_DSET)       stg_next[k] = div_setup(stg_next[k]);
      if (k >= ST_DIV && k < ST_UNIT)
        stg_next[k] = div_step(stg_next[k], 4'(ST_UNIT - 1 - k));
      if (k == ST_UNIT)       stg_next[k] = unit_step(stg_next[k]);
      if (k == ST_PROD)       stg_next[k] = prod_step(stg_next[k]);
      if (k == ST_WPROD)      stg_next[k] = wprod_step(stg_next[k]);
      if (k == ST_OUT)        stg_next[k] = out_step(stg_next[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) stg[k] <= stg_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld[NST-1];
  assign r00 = stg[NST-1].rr[0];
  assign r01 = stg[NST-1].rr[1];
  assign r02 = stg[NST-1].rr[2];
  assign r10 = stg[NST-1].rr[3];
  assign r11 = stg[NST-1].rr[4];
  assign r12 = stg[NST-1].rr[5];
  assign r20 = stg[NST-1].rr[6];
  assign r21 = stg[NST-1].rr[7];
  assign r22 = stg[NST-1].rr[8];

endmodule
`default_nettype wire
